[rtl/hgp_pkg.sv]
// shared types, constants and helper functions of the http get request parser
package hgp_pkg;

	localparam int unsigned MAX_URI_BYTES_DEF = 512;
	localparam int unsigned MAX_VERSION_BYTES_DEF = 16;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_CR = 8'd13;
	localparam logic [7:0] CH_LF = 8'd10;
	localparam logic [7:0] CH_G = 8'h47;
	localparam logic [7:0] CH_E = 8'h45;
	localparam logic [7:0] CH_T = 8'h54;

	typedef enum logic [2:0] {
		PH_METHOD,
		PH_URI,
		PH_HEX_HI,
		PH_HEX_LO,
		PH_VERSION,
		PH_HEADER,
		PH_HALT
	} phase_t;

	typedef enum logic [2:0] {
		EV_UNIT,
		EV_PATH_END,
		EV_COMPLETE,
		EV_BAD_METHOD,
		EV_BAD_LINE,
		EV_TOO_LONG,
		EV_CLOSED
	} event_t;

	// fixed-width parser state; the length counters travel separately
	typedef struct packed {
		phase_t      phase;
		logic [1:0]  method_cnt;
		logic        method_ok;
		logic [3:0]  hex_hi;
		logic [15:0] code_acc;
		logic [1:0]  utf_pend;
		logic        prev_cr;
		logic [1:0]  line_len;
	} parse_state_t;

	typedef struct packed {
		logic        valid;
		event_t      kind;
		logic [15:0] unit;
	} parse_result_t;

	localparam parse_state_t STATE_START = '{
		phase:      PH_METHOD,
		method_cnt: 2'd0,
		method_ok:  1'b1,
		hex_hi:     4'd0,
		code_acc:   16'd0,
		utf_pend:   2'd0,
		prev_cr:    1'b0,
		line_len:   2'd0
	};

	function automatic logic [3:0] hex_digit(input logic [7:0] c);
		logic [3:0] d;
		d = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			d = 4'(c - 8'h30);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			d = 4'(c - 8'h37);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			d = 4'(c - 8'h57);
		end
		return d;
	endfunction

	function automatic logic [7:0] method_char(input logic [1:0] idx);
		logic [7:0] c;
		case (idx)
			2'd0: c = CH_G;
			2'd1: c = CH_E;
			default: c = CH_T;
		endcase
		return c;
	endfunction

endpackage

[rtl/hgp_step.sv]
// next-state and event logic for one received byte
module hgp_step #(
	parameter int unsigned MAX_URI_BYTES = hgp_pkg::MAX_URI_BYTES_DEF,
	parameter int unsigned MAX_VERSION_BYTES = hgp_pkg::MAX_VERSION_BYTES_DEF,
	localparam int unsigned UW = $clog2(MAX_URI_BYTES + 1),
	localparam int unsigned VW = $clog2(MAX_VERSION_BYTES + 1)
) (
	input  hgp_pkg::parse_state_t  cur,
	input  logic [UW-1:0]          uri_cnt,
	input  logic [VW-1:0]          ver_cnt,
	input  logic [7:0]             rx_byte,
	input  logic                   peer_closed,
	output hgp_pkg::parse_state_t  nxt,
	output logic [UW-1:0]          uri_cnt_nxt,
	output logic [VW-1:0]          ver_cnt_nxt,
	output hgp_pkg::parse_result_t res
);

	logic       uri_full;
	logic       ver_full;
	logic [7:0] data_b;
	logic       is_uri_data;

	assign uri_full = (uri_cnt >= UW'(MAX_URI_BYTES));
	assign ver_full = (ver_cnt >= VW'(MAX_VERSION_BYTES));
	// decoded data byte: escape value in the low hex phase, raw byte otherwise
	assign data_b = (cur.phase == hgp_pkg::PH_HEX_LO) ?
		{cur.hex_hi, hgp_pkg::hex_digit(rx_byte)} : rx_byte;
	assign is_uri_data = !peer_closed &&
		((cur.phase == hgp_pkg::PH_HEX_LO) ||
		 (cur.phase == hgp_pkg::PH_URI && rx_byte != hgp_pkg::CH_SPACE &&
		  rx_byte != hgp_pkg::CH_PERCENT));

	// next state
	always_comb begin
		nxt = cur;
		uri_cnt_nxt = uri_cnt;
		ver_cnt_nxt = ver_cnt;
		if (peer_closed) begin
			nxt = hgp_pkg::STATE_START;
			uri_cnt_nxt = '0;
			ver_cnt_nxt = '0;
		end else begin
			case (cur.phase)
				hgp_pkg::PH_METHOD: begin
					if (cur.method_cnt != 2'd3) begin
						if (rx_byte != hgp_pkg::method_char(cur.method_cnt)) begin
							nxt.method_ok = 1'b0;
						end
						nxt.method_cnt = cur.method_cnt + 2'd1;
					end else begin
						nxt.method_cnt = 2'd0;
						if (!cur.method_ok) begin
							nxt.phase = hgp_pkg::PH_HALT;
						end else begin
							nxt.phase = hgp_pkg::PH_URI;
							uri_cnt_nxt = '0;
							nxt.utf_pend = 2'd0;
							nxt.code_acc = 16'd0;
						end
					end
				end
				hgp_pkg::PH_URI: begin
					if (rx_byte == hgp_pkg::CH_SPACE) begin
						nxt.utf_pend = 2'd0;
						nxt.code_acc = 16'd0;
						nxt.phase = hgp_pkg::PH_VERSION;
						ver_cnt_nxt = '0;
						nxt.prev_cr = 1'b0;
					end else if (rx_byte == hgp_pkg::CH_PERCENT) begin
						nxt.phase = hgp_pkg::PH_HEX_HI;
					end
				end
				hgp_pkg::PH_HEX_HI: begin
					nxt.hex_hi = hgp_pkg::hex_digit(rx_byte);
					nxt.phase = hgp_pkg::PH_HEX_LO;
				end
				hgp_pkg::PH_HEX_LO: begin
					nxt.phase = hgp_pkg::PH_URI;
				end
				hgp_pkg::PH_VERSION: begin
					if (ver_full) begin
						nxt.phase = hgp_pkg::PH_HALT;
					end else begin
						ver_cnt_nxt = ver_cnt + VW'(1);
						if (rx_byte == hgp_pkg::CH_LF) begin
							if (ver_cnt == '0 || !cur.prev_cr) begin
								nxt.phase = hgp_pkg::PH_HALT;
							end else begin
								nxt.phase = hgp_pkg::PH_HEADER;
								nxt.line_len = 2'd0;
							end
						end else begin
							nxt.prev_cr = (rx_byte == hgp_pkg::CH_CR);
						end
					end
				end
				hgp_pkg::PH_HEADER: begin
					if (rx_byte == hgp_pkg::CH_LF) begin
						if (cur.line_len == 2'd1) begin
							nxt = hgp_pkg::STATE_START;
							uri_cnt_nxt = '0;
							ver_cnt_nxt = '0;
						end else begin
							nxt.line_len = 2'd0;
						end
					end else if (cur.line_len != 2'd2) begin
						nxt.line_len = cur.line_len + 2'd1;
					end
				end
				default: begin
				end
			endcase

			// uri data byte: length check, then utf-8 accumulation
			if (is_uri_data) begin
				if (uri_full) begin
					nxt.phase = hgp_pkg::PH_HALT;
				end else begin
					uri_cnt_nxt = uri_cnt + UW'(1);
					if (cur.utf_pend != 2'd0) begin
						nxt.code_acc = {cur.code_acc[9:0], data_b[5:0]};
						nxt.utf_pend = cur.utf_pend - 2'd1;
					end else if (data_b[7:5] == 3'b110) begin
						nxt.code_acc = {11'd0, data_b[4:0]};
						nxt.utf_pend = 2'd1;
					end else if (data_b[7:4] == 4'b1110) begin
						nxt.code_acc = {12'd0, data_b[3:0]};
						nxt.utf_pend = 2'd2;
					end
				end
			end
		end
	end

	// event for this byte
	always_comb begin
		res.valid = 1'b0;
		res.kind = hgp_pkg::EV_UNIT;
		res.unit = 16'd0;
		if (peer_closed) begin
			res.valid = 1'b1;
			res.kind = hgp_pkg::EV_CLOSED;
		end else if (is_uri_data) begin
			if (uri_full) begin
				res.valid = 1'b1;
				res.kind = hgp_pkg::EV_TOO_LONG;
			end else if (cur.utf_pend == 2'd1) begin
				res.valid = 1'b1;
				res.unit = {cur.code_acc[9:0], data_b[5:0]};
			end else if (cur.utf_pend == 2'd0 && !data_b[7]) begin
				res.valid = 1'b1;
				res.unit = {8'd0, data_b};
			end
		end else begin
			case (cur.phase)
				hgp_pkg::PH_METHOD: begin
					if (cur.method_cnt == 2'd3 && !cur.method_ok) begin
						res.valid = 1'b1;
						res.kind = hgp_pkg::EV_BAD_METHOD;
					end
				end
				hgp_pkg::PH_URI: begin
					if (rx_byte == hgp_pkg::CH_SPACE) begin
						res.valid = 1'b1;
						res.kind = hgp_pkg::EV_PATH_END;
					end
				end
				hgp_pkg::PH_VERSION: begin
					if (ver_full) begin
						res.valid = 1'b1;
						res.kind = hgp_pkg::EV_TOO_LONG;
					end else if (rx_byte == hgp_pkg::CH_LF &&
						(ver_cnt == '0 || !cur.prev_cr)) begin
						res.valid = 1'b1;
						res.kind = hgp_pkg::EV_BAD_LINE;
					end
				end
				hgp_pkg::PH_HEADER: begin
					if (rx_byte == hgp_pkg::CH_LF && cur.line_len == 2'd1) begin
						res.valid = 1'b1;
						res.kind = hgp_pkg::EV_COMPLETE;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

[rtl/http_get_request_parser_unit.sv]
// top level of the http get request parser: input register, byte step, result register
// an accepted byte is held in the input register, then its event in the result register
// the parser state updates as each byte leaves the input register
// throughput: one byte per cycle while out_stall does not hold the result register
// a byte that causes no event shows nothing on the output side
// reset (arst_n low, asynchronous) returns the parser to the method phase, both registers empty
module http_get_request_parser_unit #(
	parameter int unsigned MAX_URI_BYTES = hgp_pkg::MAX_URI_BYTES_DEF,
	parameter int unsigned MAX_VERSION_BYTES = hgp_pkg::MAX_VERSION_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	input  logic        peer_closed,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  event_kind,
	output logic [15:0] path_unit
);

	localparam int unsigned UW = $clog2(MAX_URI_BYTES + 1);
	localparam int unsigned VW = $clog2(MAX_VERSION_BYTES + 1);

	// input register stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       closed_s1;

	// parser state
	hgp_pkg::parse_state_t state_q;
	logic [UW-1:0]         uri_cnt_q;
	logic [VW-1:0]         ver_cnt_q;

	hgp_pkg::parse_state_t  state_nxt;
	logic [UW-1:0]          uri_cnt_nxt;
	logic [VW-1:0]          ver_cnt_nxt;
	hgp_pkg::parse_result_t res;

	// result register
	logic        out_valid_q;
	logic [2:0]  kind_q;
	logic [15:0] unit_q;

	logic in_xfer;
	logic advance;

	// the stage-1 byte moves on whenever the result register is free or draining
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_xfer  = in_valid && !in_stall;

	hgp_step #(
		.MAX_URI_BYTES    (MAX_URI_BYTES),
		.MAX_VERSION_BYTES(MAX_VERSION_BYTES)
	) u_step (
		.cur        (state_q),
		.uri_cnt    (uri_cnt_q),
		.ver_cnt    (ver_cnt_q),
		.rx_byte    (byte_s1),
		.peer_closed(closed_s1),
		.nxt        (state_nxt),
		.uri_cnt_nxt(uri_cnt_nxt),
		.ver_cnt_nxt(ver_cnt_nxt),
		.res        (res)
	);

	// stage-1 occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// stage-1 payload, taken on every input transfer
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			byte_s1   <= rx_byte;
			closed_s1 <= peer_closed;
		end
	end

	// parser state steps once per byte that leaves stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= hgp_pkg::STATE_START;
			uri_cnt_q <= '0;
			ver_cnt_q <= '0;
		end else if (advance) begin
			state_q   <= state_nxt;
			uri_cnt_q <= uri_cnt_nxt;
			ver_cnt_q <= ver_cnt_nxt;
		end
	end

	// result register: loads on advance, empties on an output transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res.valid;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			kind_q <= res.kind;
			unit_q <= res.unit;
		end
	end

	assign out_valid  = out_valid_q;
	assign event_kind = kind_q;
	assign path_unit  = unit_q;

endmodule

[rtl/hgp_checker.sv]
// port-level checks of the http get request parser, bound to the top level
module hgp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [7:0]  rx_byte,
	input logic        peer_closed,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  event_kind,
	input logic [15:0] path_unit
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(event_kind) && $stable(path_unit))
		else $error("result changed while stalled");

	// input only backs up behind a blocked result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with free result register");

	// path unit is zero on every event other than a path unit
	a_unit_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_kind != 3'(hgp_pkg::EV_UNIT) |-> path_unit == 16'd0)
		else $error("nonzero path unit on non-unit event");

	// no event code beyond closed
	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> event_kind <= 3'(hgp_pkg::EV_CLOSED))
		else $error("undefined event code");

endmodule

bind http_get_request_parser_unit hgp_checker u_hgp_checker (.*);

[dv/hgp_event_checker.sv]
// event checker of the http get request parser: byte-level parser prediction and event compare
module hgp_event_checker
	import hgp_pkg::*;
#(
	parameter int unsigned MAX_URI_BYTES = MAX_URI_BYTES_DEF,
	parameter int unsigned MAX_VERSION_BYTES = MAX_VERSION_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  rx_byte,
	input  logic        peer_closed,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [2:0]  event_kind,
	input  logic [15:0] path_unit,
	output int unsigned pending,
	output int unsigned fail_count
);

	typedef struct packed {
		event_t      kind;
		logic [15:0] unit;
	} parser_event_t;

	parser_event_t expected_events[$];
	parser_event_t oldest;
	int unsigned   errors = 0;

	// predicted parser state
	phase_t      stage;
	logic [1:0]  method_seen;
	logic        method_good;
	int unsigned uri_bytes;
	logic [7:0]  escape_hi;
	logic [15:0] unit_acc;
	logic [1:0]  units_owed;
	logic [7:0]  last_version_byte;
	int unsigned version_bytes;
	logic [1:0]  header_len;

	function automatic logic [7:0] nibble_value(input logic [7:0] c);
		logic [7:0] v;
		v = 8'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = c - 8'h30;
		end else if (c >= 8'h41 && c <= 8'h46) begin
			v = c - 8'h41 + 8'd10;
		end else if (c >= 8'h61 && c <= 8'h66) begin
			v = c - 8'h61 + 8'd10;
		end
		return v;
	endfunction

	task automatic restart_parser();
		stage = PH_METHOD;
		method_seen = 2'd0;
		method_good = 1'b1;
		uri_bytes = 0;
		escape_hi = 8'd0;
		unit_acc = 16'd0;
		units_owed = 2'd0;
		last_version_byte = 8'd0;
		version_bytes = 0;
		header_len = 2'd0;
	endtask

	task automatic post_event(input event_t kind, input logic [15:0] unit);
		parser_event_t ev;
		ev.kind = kind;
		ev.unit = unit;
		expected_events.push_back(ev);
	endtask

	// one decoded uri data byte: length limit, then utf-8 to utf-16
	task automatic take_path_byte(input logic [7:0] b);
		if (uri_bytes >= MAX_URI_BYTES) begin
			stage = PH_HALT;
			post_event(EV_TOO_LONG, 16'd0);
			return;
		end
		uri_bytes++;
		if (units_owed != 2'd0) begin
			unit_acc = {unit_acc[9:0], b[5:0]};
			units_owed = units_owed - 2'd1;
			if (units_owed == 2'd0) post_event(EV_UNIT, unit_acc);
		end else if (!b[7]) begin
			post_event(EV_UNIT, {8'd0, b});
		end else if (b[7:5] == 3'b110) begin
			unit_acc = {11'd0, b[4:0]};
			units_owed = 2'd1;
		end else if (b[7:4] == 4'b1110) begin
			unit_acc = {12'd0, b[3:0]};
			units_owed = 2'd2;
		end
	endtask

	task automatic advance_parser(input logic [7:0] b, input logic closed);
		logic [7:0] letter;
		if (closed) begin
			restart_parser();
			post_event(EV_CLOSED, 16'd0);
			return;
		end
		case (stage)
			PH_METHOD: begin
				letter = (method_seen == 2'd0) ? CH_G : (method_seen == 2'd1) ? CH_E : CH_T;
				if (method_seen < 2'd3) begin
					if (b != letter) method_good = 1'b0;
					method_seen = method_seen + 2'd1;
				end else begin
					method_seen = 2'd0;
					if (!method_good) begin
						stage = PH_HALT;
						post_event(EV_BAD_METHOD, 16'd0);
					end else begin
						stage = PH_URI;
						uri_bytes = 0;
						units_owed = 2'd0;
						unit_acc = 16'd0;
					end
				end
			end
			PH_URI: begin
				if (b == CH_SPACE) begin
					units_owed = 2'd0;
					unit_acc = 16'd0;
					stage = PH_VERSION;
					version_bytes = 0;
					last_version_byte = 8'd0;
					post_event(EV_PATH_END, 16'd0);
				end else if (b == CH_PERCENT) begin
					stage = PH_HEX_HI;
				end else begin
					take_path_byte(b);
				end
			end
			PH_HEX_HI: begin
				escape_hi = nibble_value(b) << 4;
				stage = PH_HEX_LO;
			end
			PH_HEX_LO: begin
				stage = PH_URI;
				take_path_byte(escape_hi | nibble_value(b));
			end
			PH_VERSION: begin
				if (version_bytes >= MAX_VERSION_BYTES) begin
					stage = PH_HALT;
					post_event(EV_TOO_LONG, 16'd0);
				end else begin
					version_bytes++;
					if (b == CH_LF) begin
						if (version_bytes < 2 || last_version_byte != CH_CR) begin
							stage = PH_HALT;
							post_event(EV_BAD_LINE, 16'd0);
						end else begin
							stage = PH_HEADER;
							header_len = 2'd0;
						end
					end else begin
						last_version_byte = b;
					end
				end
			end
			PH_HEADER: begin
				if (b == CH_LF) begin
					if (header_len == 2'd1) begin
						restart_parser();
						post_event(EV_COMPLETE, 16'd0);
					end else begin
						header_len = 2'd0;
					end
				end else if (header_len < 2'd2) begin
					header_len = header_len + 2'd1;
				end
			end
			default: begin
			end
		endcase
	endtask

	// events are compared before the new byte is predicted; latency keeps them apart
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restart_parser();
			expected_events.delete();
			pending <= 0;
			fail_count <= errors;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_events.size() == 0) begin
					$error("event_kind: expected none, actual %0d", event_kind);
					errors++;
				end else begin
					oldest = expected_events.pop_front();
					if (event_kind !== oldest.kind) begin
						$error("event_kind: expected %0d, actual %0d", oldest.kind, event_kind);
						errors++;
					end
					if (path_unit !== oldest.unit) begin
						$error("path_unit: expected 0x%04h, actual 0x%04h", oldest.unit, path_unit);
						errors++;
					end
				end
			end
			if (in_valid && !in_stall) advance_parser(rx_byte, peer_closed);
			pending <= expected_events.size();
			fail_count <= errors;
		end
	end

endmodule

[dv/http_get_request_parser_unit_tb.sv]
// testbench top of the http get request parser: byte stimulus, receiver stalls and verdict
module http_get_request_parser_unit_tb;
	import hgp_pkg::*;

	localparam int unsigned URI_LIMIT = MAX_URI_BYTES_DEF;
	localparam int unsigned VERSION_LIMIT = MAX_VERSION_BYTES_DEF;
	// no new request is started once this many bytes have been accepted
	localparam int unsigned ITEM_TARGET = 880;
	// the one over-long uri goes in after this many bytes
	localparam int unsigned LONG_URI_AFTER = 300;
	localparam int unsigned SETTLE_CYCLES = 16;
	localparam int unsigned CYCLE_LIMIT = 400000;

	// receiver behavior, switched whenever its random run length runs out
	typedef enum int {
		RX_READY,
		RX_LIGHT,
		RX_HEAVY,
		RX_PERIODIC
	} rx_mode_t;

	// one request byte, or a peer close when closed is set
	typedef struct packed {
		logic       closed;
		logic [7:0] data;
	} rx_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  rx_byte = 8'd0;
	logic        peer_closed = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  event_kind;
	logic [15:0] path_unit;

	int unsigned pending;
	int unsigned fail_count;
	int unsigned cycle_count;
	int unsigned items_sent = 0;
	int unsigned burst_left = 0;
	rx_mode_t    rx_mode = RX_READY;
	int unsigned mode_left = 0;
	bit          long_uri_done = 1'b0;

	// bytes of the request being built, sent in order
	rx_item_t request_bytes[$];

	always #10 clk = ~clk;

	http_get_request_parser_unit #(
		.MAX_URI_BYTES(URI_LIMIT),
		.MAX_VERSION_BYTES(VERSION_LIMIT)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.peer_closed(peer_closed),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.event_kind(event_kind),
		.path_unit(path_unit)
	);

	hgp_event_checker #(
		.MAX_URI_BYTES(URI_LIMIT),
		.MAX_VERSION_BYTES(VERSION_LIMIT)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.peer_closed(peer_closed),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.event_kind(event_kind),
		.path_unit(path_unit),
		.pending(pending),
		.fail_count(fail_count)
	);

	// receiver stall pattern, independent of the sender
	always @(posedge clk) begin
		if (mode_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			mode_left = $urandom_range(20, 200);
		end
		mode_left--;
		case (rx_mode)
			RX_READY:    out_stall <= 1'b0;
			RX_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
			RX_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
			RX_PERIODIC: out_stall <= ((mode_left % 5) < 2);
			default:     out_stall <= 1'b0;
		endcase
	end

	task automatic push_byte(input logic [7:0] b);
		rx_item_t it;
		it.closed = 1'b0;
		it.data = b;
		request_bytes.push_back(it);
	endtask

	// peer close; the byte beside it is ignored, so it is random
	task automatic push_close();
		rx_item_t it;
		it.closed = 1'b1;
		it.data = 8'($urandom_range(0, 255));
		request_bytes.push_back(it);
	endtask

	task automatic push_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++) push_byte(s[i]);
	endtask

	// hex digit character in random case
	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] c;
		if (nib < 4'd10) begin
			c = 8'h30 + nib;
		end else if ($urandom_range(0, 1) == 0) begin
			c = 8'h41 + nib - 8'd10;
		end else begin
			c = 8'h61 + nib - 8'd10;
		end
		return c;
	endfunction

	task automatic push_escape(input logic [7:0] b);
		push_byte(CH_PERCENT);
		push_byte(hex_char(b[7:4]));
		push_byte(hex_char(b[3:0]));
	endtask

	// any uri byte that is neither the terminating space nor an escape mark
	function automatic logic [7:0] uri_byte();
		logic [7:0] b;
		do b = 8'($urandom_range(0, 255)); while (b == CH_SPACE || b == CH_PERCENT);
		return b;
	endfunction

	function automatic logic [7:0] non_lf_byte();
		logic [7:0] b;
		do b = 8'($urandom_range(0, 255)); while (b == CH_LF);
		return b;
	endfunction

	function automatic logic [7:0] printable_byte();
		logic [7:0] b;
		do b = 8'($urandom_range(8'h21, 8'h7E)); while (b == CH_PERCENT);
		return b;
	endfunction

	// one request with random content; broken ones end in a peer close
	task automatic build_request(input bit overlong);
		int          i;
		int          n;
		int          bad_pos;
		int          cut;
		int unsigned data_bytes;
		bit          broken;
		logic [7:0]  letter;
		logic [7:0]  b;

		broken = !overlong && ($urandom_range(0, 15) == 0);
		bad_pos = $urandom_range(0, 2);

		// method: GET plus an unchecked fourth byte, or one letter corrupted
		for (i = 0; i < 3; i++) begin
			letter = (i == 0) ? CH_G : (i == 1) ? CH_E : CH_T;
			if (broken && i == bad_pos) begin
				do b = 8'($urandom_range(0, 255)); while (b == letter);
				push_byte(b);
			end else begin
				push_byte(letter);
			end
		end
		push_byte(8'($urandom_range(0, 255)));

		if (overlong) begin
			// one data byte past the limit halts the parser
			data_bytes = 0;
			while (data_bytes <= URI_LIMIT) begin
				if ($urandom_range(0, 7) == 0) push_escape(8'($urandom_range(0, 255)));
				else push_byte(printable_byte());
				data_bytes++;
			end
			broken = 1'b1;
		end else begin
			n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
			repeat (n) begin
				case ($urandom_range(0, 9))
					0, 1: push_byte(printable_byte());
					2: push_byte(uri_byte());
					3: begin
						// two-byte sequence, continuation taken unchecked
						push_byte(8'hC0 | 8'($urandom_range(0, 31)));
						push_byte(uri_byte());
					end
					4: begin
						push_byte(8'hE0 | 8'($urandom_range(0, 15)));
						push_byte(8'h80 | 8'($urandom_range(0, 63)));
						push_byte(8'h80 | 8'($urandom_range(0, 63)));
					end
					5: push_escape(8'($urandom_range(0, 255)));
					6: begin
						// escape digits of any value, space and lf included
						push_byte(CH_PERCENT);
						push_byte(8'($urandom_range(0, 255)));
						push_byte(8'($urandom_range(0, 255)));
					end
					7: begin
						// three-byte sequence entirely escaped
						push_escape(8'hE0 | 8'($urandom_range(0, 15)));
						push_escape(8'h80 | 8'($urandom_range(0, 63)));
						push_escape(8'h80 | 8'($urandom_range(0, 63)));
					end
					8: begin
						// stray continuation or four-byte lead, both skipped
						if ($urandom_range(0, 1) == 0) push_byte(8'h80 | 8'($urandom_range(0, 63)));
						else push_byte(8'hF0 | 8'($urandom_range(0, 15)));
					end
					default: begin
						// sequence cut short; the next element finishes or breaks it
						push_byte(8'hE0 | 8'($urandom_range(0, 15)));
						push_byte(8'h80 | 8'($urandom_range(0, 63)));
					end
				endcase
			end
		end
		push_byte(CH_SPACE);

		// version line
		case ($urandom_range(0, 19))
			14, 15, 16: begin
				// random content up to the length limit
				n = $urandom_range(0, VERSION_LIMIT - 2);
				repeat (n) push_byte(non_lf_byte());
				push_byte(CH_CR);
				push_byte(CH_LF);
			end
			17: begin
				n = $urandom_range(VERSION_LIMIT - 1, VERSION_LIMIT + 4);
				repeat (n) push_byte(non_lf_byte());
				push_byte(CH_CR);
				push_byte(CH_LF);
				broken = 1'b1;
			end
			18: begin
				// line end without cr
				n = $urandom_range(0, 8);
				repeat (n) push_byte(non_lf_byte());
				do b = 8'($urandom_range(0, 255)); while (b == CH_CR || b == CH_LF);
				push_byte(b);
				push_byte(CH_LF);
				broken = 1'b1;
			end
			19: begin
				push_byte(CH_LF);
				broken = 1'b1;
			end
			default: begin
				push_text("HTTP/1.");
				push_byte(8'h30 + 8'($urandom_range(0, 9)));
				push_byte(CH_CR);
				push_byte(CH_LF);
			end
		endcase

		if (broken) begin
			// parser is halted: a few ignored bytes, then the close restarts it
			repeat ($urandom_range(0, 3)) push_byte(8'($urandom_range(0, 255)));
			push_close();
		end else begin
			// header lines of length zero or at least two are skipped
			repeat ($urandom_range(0, 3)) begin
				n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 6);
				repeat (n) push_byte(non_lf_byte());
				push_byte(CH_LF);
			end
			// a one-byte line ends the request
			push_byte(($urandom_range(0, 3) == 0) ? non_lf_byte() : CH_CR);
			push_byte(CH_LF);
			if ($urandom_range(0, 15) == 0) begin
				// connection drops part way through
				cut = $urandom_range(1, request_bytes.size() - 1);
				request_bytes = request_bytes[0:cut-1];
				push_close();
			end else if ($urandom_range(0, 7) == 0) begin
				push_close();
			end
		end
	endtask

	// sends the built bytes in bursts with random gaps between them
	task automatic send_request_bytes();
		rx_item_t it;
		int       gap;
		while (request_bytes.size() != 0) begin
			it = request_bytes.pop_front();
			if (burst_left == 0) begin
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				if (gap != 0) begin
					in_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				burst_left = $urandom_range(1, 40);
			end
			in_valid <= 1'b1;
			rx_byte <= it.data;
			peer_closed <= it.closed;
			// transfer happens at the first edge without stall
			do @(posedge clk); while (in_stall);
			burst_left--;
			items_sent++;
		end
	endtask

	// run limit
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed: unchecked fourth method byte, escape with a non-hex digit
		push_text("GET");
		push_byte(8'hFF);
		push_text("%g1");
		// stray continuation and four-byte lead are skipped
		push_byte(8'h80);
		push_byte(8'hF8);
		// unfinished three-byte sequence dropped at the space
		push_byte(8'hE2);
		push_byte(8'h82);
		push_byte(CH_SPACE);
		// lf as the first version byte
		push_byte(CH_LF);
		push_close();
		// wrong method
		push_text("PUT ");
		push_close();
		// shortest complete request: empty uri, empty version, one-byte header line
		push_text("GET  ");
		push_byte(CH_CR);
		push_byte(CH_LF);
		push_text("x");
		push_byte(CH_LF);
		send_request_bytes();

		// random requests, one of them with an over-long uri
		while (items_sent < ITEM_TARGET) begin
			if (!long_uri_done && items_sent >= LONG_URI_AFTER) begin
				build_request(1'b1);
				long_uri_done = 1'b1;
			end else begin
				build_request(1'b0);
			end
			send_request_bytes();
		end
		in_valid <= 1'b0;

		// drain, then give the parser time to show anything unexpected
		// one edge first so the count includes the last transfer
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
